### rtl/csfr_pkg.sv
// Shared types and constants for the checksum-synced frame receiver.
package csfr_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned WIN_DEPTH = HDR_BYTES - 1;
	localparam int unsigned FILL_W    = $clog2(HDR_BYTES);

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] dest_addr;
		logic [7:0] src_addr;
		logic [7:0] frame_len;
		logic [7:0] check_byte;
		logic [7:0] data_byte;
		logic       last;
	} out_item_t;

endpackage

### rtl/csfr_in_if.sv
// Input byte channel: valid/ready handshake carrying one received byte.
interface csfr_in_if;
	import csfr_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/csfr_out_if.sv
// Result channel: valid/ready handshake carrying one header or payload result.
interface csfr_out_if;
	import csfr_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/csfr_core.sv
// Header hunt and deframing state with next-result logic for one byte.
module csfr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output logic                res_valid,
	output csfr_pkg::out_item_t res
);
	import csfr_pkg::*;

	logic [7:0]        win_q [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic              in_payload_q;
	logic [7:0]        bytes_left_q;
	logic [7:0]        hdr_dest_q;
	logic [7:0]        hdr_src_q;
	logic [7:0]        hdr_len_q;
	logic [7:0]        hdr_check_q;

	logic       payload_now;
	logic [7:0] left_dec;
	logic [7:0] sum;
	logic       win_full;
	logic       hdr_hit;

	assign payload_now = in_payload_q && (bytes_left_q != 8'd0);
	assign left_dec    = bytes_left_q - 8'd1;
	assign win_full    = (fill_q == FILL_W'(WIN_DEPTH));
	assign sum         = win_q[0] + win_q[1] + win_q[2] + rx_byte;
	assign hdr_hit     = !payload_now && win_full && (sum == 8'd0);

	always_comb begin
		res_valid      = payload_now || hdr_hit;
		res.kind       = payload_now ? KIND_PAYLOAD : KIND_HEADER;
		res.dest_addr  = payload_now ? hdr_dest_q : win_q[0];
		res.src_addr   = payload_now ? hdr_src_q : win_q[1];
		res.frame_len  = payload_now ? hdr_len_q : win_q[2];
		res.check_byte = payload_now ? hdr_check_q : rx_byte;
		res.data_byte  = payload_now ? rx_byte : 8'd0;
		res.last       = payload_now ? (left_dec == 8'd0) : (win_q[2] == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= 8'd0;
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			bytes_left_q <= 8'd0;
			hdr_dest_q   <= 8'd0;
			hdr_src_q    <= 8'd0;
			hdr_len_q    <= 8'd0;
			hdr_check_q  <= 8'd0;
		end else if (step) begin
			if (payload_now) begin
				bytes_left_q <= left_dec;
				if (left_dec == 8'd0) begin
					in_payload_q <= 1'b0;
					fill_q       <= '0;
				end
			end else if (!win_full) begin
				in_payload_q                    <= 1'b0;
				win_q[fill_q[FILL_W-1:0]]        <= rx_byte;
				fill_q                          <= fill_q + FILL_W'(1);
			end else if (!hdr_hit) begin
				in_payload_q <= 1'b0;
				win_q[0]     <= win_q[1];
				win_q[1]     <= win_q[2];
				win_q[2]     <= rx_byte;
			end else begin
				hdr_dest_q   <= win_q[0];
				hdr_src_q    <= win_q[1];
				hdr_len_q    <= win_q[2];
				hdr_check_q  <= rx_byte;
				fill_q       <= '0;
				bytes_left_q <= win_q[2];
				in_payload_q <= (win_q[2] != 8'd0);
			end
		end
	end

endmodule

### rtl/csfr_out_reg.sv
// Result register with skid stage so input transfers continue under a stall.
module csfr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  csfr_pkg::out_item_t push_data,
	output logic                can_take,
	csfr_out_if.source          out
);
	import csfr_pkg::*;

	logic      main_vld_q;
	logic      skid_vld_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = main_vld_q && out.ready;
	assign can_take  = !skid_vld_q;
	assign out.valid = main_vld_q;
	assign out.data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!main_vld_q || pop) begin
				main_vld_q <= skid_vld_q || push;
				skid_vld_q <= 1'b0;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || pop) begin
			main_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

### rtl/checksum_synced_frame_receiver_unit.sv
// Top level of the checksum-synced frame receiver.
//
//   channel  dir  payload                                           handshake
//   rx       in   rx_byte[7:0]                                      valid/ready
//   res      out  kind dest_addr src_addr frame_len check_byte      valid/ready
//                 data_byte last
//
// One byte per cycle while rx.ready is high; results reach res from a register.
// The sum is combinational; the window shift and payload count are registered.
// A two-entry result register lets rx keep moving while res stalls;
// rx.ready drops only while both entries are full.
// Reset clears the window, fill count, payload state and result valids.
module checksum_synced_frame_receiver_unit (
	input  logic       clk,
	input  logic       arst_n,
	csfr_in_if.sink    rx,
	csfr_out_if.source res
);
	import csfr_pkg::*;

	logic      can_take;
	logic      step;
	logic      res_valid;
	out_item_t res_item;

	assign rx.ready = can_take;
	assign step     = rx.valid && can_take;

	csfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx.data.rx_byte),
		.res_valid (res_valid),
		.res       (res_item)
	);

	csfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && res_valid),
		.push_data (res_item),
		.can_take  (can_take),
		.out       (res)
	);

endmodule

### rtl/csfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module csfr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rx_ready,
	input logic                res_valid,
	input logic                res_ready,
	input csfr_pkg::out_item_t res_data
);
	import csfr_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_hdr_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_HEADER |-> res_data.data_byte == 8'd0)
		else $error("header result with nonzero data byte");

	a_hdr_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_HEADER |->
		8'(res_data.dest_addr + res_data.src_addr + res_data.frame_len
			+ res_data.check_byte) == 8'd0)
		else $error("header result with bad checksum");

	a_zero_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_HEADER |->
		res_data.last == (res_data.frame_len == 8'd0))
		else $error("header last flag disagrees with length");

	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready && res_ready |=> rx_ready)
		else $error("input stalled after result drained");

endmodule

bind checksum_synced_frame_receiver_unit csfr_checker u_csfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

### tb/sv/tb_checksum_synced_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Testbench for the frame receiver: drives byte streams and checks every result against a model.
module tb_checksum_synced_frame_receiver_unit;
	import csfr_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	csfr_in_if  rx_if ();
	csfr_out_if res_if ();

	checksum_synced_frame_receiver_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [7:0] pending_bytes [$];
	out_item_t  expected_results [$];
	int         queued_count = 0;
	int         fail_count = 0;
	int         send_idle_pct = 13;
	int         sink_idle_pct = 77;
	bit         rx_busy = 1'b0;

	logic [7:0] win [3];
	logic [1:0] win_fill;
	logic       in_frame;
	logic [7:0] bytes_left;
	logic [7:0] h_dest, h_src, h_len, h_chk;

	function automatic out_item_t frame_result(kind_t kind, logic [7:0] data, logic last);
		out_item_t r;
		r.kind       = kind;
		r.dest_addr  = h_dest;
		r.src_addr   = h_src;
		r.frame_len  = h_len;
		r.check_byte = h_chk;
		r.data_byte  = data;
		r.last       = last;
		return r;
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		logic [7:0] sum;
		if (in_frame && bytes_left == 8'd0) begin
			in_frame = 1'b0;
			win_fill = 2'd0;
		end
		if (in_frame) begin
			bytes_left = bytes_left - 8'd1;
			expected_results.push_back(frame_result(KIND_PAYLOAD, b, bytes_left == 8'd0));
			if (bytes_left == 8'd0) begin
				in_frame = 1'b0;
				win_fill = 2'd0;
			end
			return;
		end
		if (win_fill < 2'd3) begin
			win[win_fill] = b;
			win_fill = win_fill + 2'd1;
			return;
		end
		sum = win[0] + win[1] + win[2] + b;
		if (sum != 8'd0) begin
			win[0] = win[1];
			win[1] = win[2];
			win[2] = b;
			return;
		end
		h_dest = win[0];
		h_src = win[1];
		h_len = win[2];
		h_chk = b;
		win_fill = 2'd0;
		bytes_left = h_len;
		in_frame = (h_len != 8'd0);
		expected_results.push_back(frame_result(KIND_HEADER, 8'd0, h_len == 8'd0));
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		bit bad;
		if (expected_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("tb: unexpected result kind=%0d data=%h last=%b",
					got.kind, got.data_byte, got.last);
			return;
		end
		want = expected_results.pop_front();
		bad = (got.kind !== want.kind) || (got.dest_addr !== want.dest_addr) ||
			(got.src_addr !== want.src_addr) || (got.frame_len !== want.frame_len) ||
			(got.check_byte !== want.check_byte) || (got.data_byte !== want.data_byte) ||
			(got.last !== want.last);
		if (bad) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("tb: mismatch expected kind=%0d dst=%h src=%h len=%h chk=%h dat=%h last=%b",
					want.kind, want.dest_addr, want.src_addr, want.frame_len,
					want.check_byte, want.data_byte, want.last);
				$display("tb:          actual   kind=%0d dst=%h src=%h len=%h chk=%h dat=%h last=%b",
					got.kind, got.dest_addr, got.src_addr, got.frame_len,
					got.check_byte, got.data_byte, got.last);
			end
		end
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		queued_count++;
	endtask

	task automatic queue_header(input logic [7:0] dest, src, len, input bit broken);
		logic [7:0] chk;
		chk = 8'd0 - dest - src - len;
		if (broken)
			chk = chk + 8'($urandom_range(1, 255));
		queue_byte(dest);
		queue_byte(src);
		queue_byte(len);
		queue_byte(chk);
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || rx_busy || expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
		end else if (!rx_busy) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rx_if.data.rx_byte <= pending_bytes.pop_front();
				rx_if.valid <= 1'b1;
				rx_busy = 1'b1;
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready) begin
				deframe_byte(rx_if.data.rx_byte);
				rx_busy = 1'b0;
			end
			if (res_if.valid && res_if.ready)
				check_result(res_if.data);
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int pick;
		int target;
		logic [7:0] len;
		rx_if.valid = 1'b0;
		rx_if.data = '0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		win = '{8'd0, 8'd0, 8'd0};
		win_fill = 2'd0;
		in_frame = 1'b0;
		bytes_left = 8'd0;
		h_dest = 8'd0;
		h_src = 8'd0;
		h_len = 8'd0;
		h_chk = 8'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero-length frame right after reset, all-ones address fields, payload extremes
		queue_header(8'h00, 8'h00, 8'h00, 1'b0);
		queue_header(8'hFF, 8'hFF, 8'h01, 1'b0);
		queue_byte(8'hFF);
		queue_header(8'h12, 8'h34, 8'h02, 1'b0);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		// broken header, then a stray byte, then a good frame found by sliding
		queue_header(8'h01, 8'h02, 8'h03, 1'b1);
		queue_byte(8'h80);
		queue_header(8'hA5, 8'h5A, 8'h00, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 77 : 0;
			sink_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 13 : 0;
			target = queued_count + 410;
			while (queued_count < target) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					if ($urandom_range(199) == 0)
						len = 8'hFF;
					else if ($urandom_range(9) == 0)
						len = 8'($urandom_range(9, 40));
					else
						len = 8'($urandom_range(0, 8));
					queue_header(8'($urandom), 8'($urandom), len, 1'b0);
					repeat (len) queue_byte(8'($urandom));
				end else if (pick < 85) begin
					queue_header(8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)), 1'b1);
				end else begin
					repeat ($urandom_range(1, 5)) queue_byte(8'($urandom));
				end
			end
			// hold the sender until every result of this phase is back
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
